// ----- design/csi_pkg.sv -----
`default_nettype none
package csi_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULN,
    ST_DIV,
    ST_CLAMP,
    ST_READ,
    ST_COEF,
    ST_MSET,
    ST_MUL,
    ST_FIN,
    ST_RES,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_KNOT_COUNT = 3'd0,
    REG_RANGE_MIN  = 3'd1,
    REG_RANGE_MAX  = 3'd2,
    REG_EXTRAP     = 3'd3
  } cfg_reg_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic signed [63:0] SAT62 = 64'sh4000_0000_0000_0000;

endpackage
`default_nettype wire

// ----- design/cubic_spline_interp_1d.sv -----
`default_nettype none
// load transfer: written in the cycle it is taken; the next item may follow in the next cycle
// refused query (empty range or outside without extrapolation): goes from ST_IDLE to ST_OUT
// evaluated query: a one-bit-per-cycle divider finds the knot interval and fraction, then
//   three Horner steps run on one 32x32 multiplier
// one item in flight; a result may wait in the output register while the next item is taken
// rst (synchronous) clears control and configuration; the knot table is not cleared
module cubic_spline_interp_1d #(
  parameter int MAX_KNOTS = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // knot_index[7:0], knot_value[39:8], query_x[71:40]
  input  wire logic        s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // result[31:0]
  output logic             m_tuser,   // out_of_range
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);
  import csi_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int DW = 42 + FRAC_BITS;
  localparam int QW = DW + 1 - FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [63:0] TLIM = 64'sd1 <<< (62 - FRAC_BITS);

  // configuration
  logic [8:0]         knot_count;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;
  logic               extrapolate;

  state_t state, state_next;

  logic [31:0] mem [MAX_KNOTS];
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_rdata;

  logic signed [32:0] xd;
  logic signed [32:0] den;
  logic               qneg;
  logic [32:0]        rem;
  logic [DW-1:0]      quo;
  logic [CW-1:0]      cnt;
  logic [8:0]         k;
  logic signed [63:0] tq;
  logic [2:0]         rcnt;
  logic signed [31:0] pk [4];
  logic signed [39:0] c2, d0, f0;
  logic signed [63:0] acc;
  logic [1:0]         hstep;
  logic [62:0]        amag, bmag;
  logic               mneg;
  logic [2:0]         mcnt;
  logic [63:0]        pp;
  logic [6:0]         pp_sh;
  logic [127:0]       prod;
  logic [31:0]        res_data;
  logic               res_oor;

  logic [8:0] n;
  logic       in_xfer, out_free, trivial;
  logic signed [31:0] qx;

  always_comb begin
    if (knot_count < 9'd2) n = 9'd2;
    else if (32'(knot_count) > MAX_KNOTS) n = 9'(MAX_KNOTS);
    else n = knot_count;
  end

  assign qx       = $signed(s_tdata[71:40]);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign trivial  = (range_max <= range_min) ||
                    (((qx < range_min) || (qx > range_max)) && !extrapolate);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_xfer && s_tuser == FUNC_QUERY) state_next = trivial ? ST_OUT : ST_MULN;
      ST_MULN:  state_next = ST_DIV;
      ST_DIV:   if (cnt == CW'(1)) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_READ;
      ST_READ:  if (rcnt == 3'd4) state_next = ST_COEF;
      ST_COEF:  state_next = ST_MSET;
      ST_MSET:  state_next = ST_MUL;
      ST_MUL:   if (mcnt == 3'd4) state_next = ST_FIN;
      ST_FIN:   state_next = (hstep == 2'd2) ? ST_RES : ST_MSET;
      ST_RES:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    logic [31:0] idx32;
    logic [31:0] ra;
    idx32    = 32'(s_tdata[7:0]);
    ra       = 32'(k) + 32'(rcnt) - 32'd1;
    s_tready = (state == ST_IDLE);
    mem_we   = 1'b0;
    mem_addr = ra[AW-1:0];
    if (state == ST_IDLE) begin
      mem_addr = idx32[AW-1:0];
      mem_we   = in_xfer && (s_tuser == FUNC_LOAD) && (idx32 < 32'(MAX_KNOTS));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= s_tdata[39:8];
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      knot_count  <= 9'd2;
      range_min   <= 32'sd0;
      range_max   <= 32'sd65536;
      extrapolate <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_KNOT_COUNT: knot_count  <= cfg_data[8:0];
          REG_RANGE_MIN:  range_min   <= $signed(cfg_data);
          REG_RANGE_MAX:  range_max   <= $signed(cfg_data);
          REG_EXTRAP:     extrapolate <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= res_data;
      m_tuser <= res_oor;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic signed [42:0]   num;
    logic [42:0]          nmag;
    logic [33:0]          trial;
    logic signed [DW:0]   qf;
    logic signed [QW-1:0] whole;
    logic signed [QW-1:0] wk;
    logic signed [63:0]   w64;
    logic [8:0]           nm2;
    logic signed [39:0]   kf0, kf1, kd0, kd1;
    logic [127:0]         shd;
    logic [63:0]          mag;
    logic signed [63:0]   sv, sum, addend;
    logic signed [63:0]   half;
    num = xd * $signed({1'b0, n - 9'd1});
    nmag = num[42] ? 43'(-num) : 43'(num);
    trial = {rem, quo[DW-1]};
    qf = qneg ? -($signed({1'b0, quo}) + (DW+1)'(rem != 33'd0)) : $signed({1'b0, quo});
    whole = QW'(qf >>> FRAC_BITS);
    nm2 = n - 9'd2;
    kf0 = 40'(pk[1]) <<< 1;
    kf1 = 40'(pk[2]) <<< 1;
    kd0 = (k != 9'd0) ? 40'(pk[2]) - 40'(pk[0]) : kf1 - kf0;
    kd1 = (32'(k) + 32'd2 < 32'(n)) ? 40'(pk[3]) - 40'(pk[1]) : kf1 - kf0;
    shd = prod >> FRAC_BITS;
    mag = (shd > 128'(SAT62)) ? SAT62 : shd[63:0];
    sv = mneg ? -$signed(mag) : $signed(mag);
    case (hstep)
      2'd0:    addend = 64'(c2);
      2'd1:    addend = 64'(d0);
      default: addend = 64'(f0);
    endcase
    sum = sv + addend;
    half = acc >>> 1;
    wk = '0;
    w64 = '0;
    case (state)
      ST_IDLE: begin
        xd  <= 33'(qx) - 33'(range_min);
        den <= 33'(range_max) - 33'(range_min);
        res_data <= 32'd0;
        res_oor  <= trivial;
      end
      ST_MULN: begin
        qneg <= num[42];
        quo  <= {nmag[41:0], {FRAC_BITS{1'b0}}};
        rem  <= '0;
        cnt  <= CW'(DW);
      end
      ST_DIV: begin
        if (trial >= 34'(den)) begin
          rem <= 33'(trial - 34'(den));
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= trial[32:0];
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
      end
      ST_CLAMP: begin
        if (whole < 0) begin
          k  <= 9'd0;
          wk = whole;
        end else if (whole > $signed(QW'(nm2))) begin
          k  <= nm2;
          wk = whole - $signed(QW'(nm2));
        end else begin
          k  <= 9'(whole);
          wk = '0;
        end
        w64 = 64'(wk);
        if (w64 >= TLIM) tq <= SAT62;
        else if (w64 < -TLIM) tq <= -SAT62;
        else tq <= (w64 <<< FRAC_BITS) + 64'(qf[FRAC_BITS-1:0]);
        rcnt <= 3'd0;
      end
      ST_READ: begin
        if (rcnt != 3'd0) pk[2'(rcnt - 3'd1)] <= $signed(mem_rdata);
        rcnt <= rcnt + 3'd1;
      end
      ST_COEF: begin
        acc   <= 64'((kf0 <<< 1) - (kf1 <<< 1) + kd0 + kd1);
        c2    <= -(3 * kf0) + 3 * kf1 - (kd0 <<< 1) - kd1;
        d0    <= kd0;
        f0    <= kf0;
        hstep <= 2'd0;
      end
      ST_MSET: begin
        amag <= acc[63] ? 63'(-acc) : 63'(acc);
        bmag <= tq[63] ? 63'(-tq) : 63'(tq);
        mneg <= acc[63] ^ tq[63];
        mcnt <= 3'd0;
        prod <= '0;
      end
      ST_MUL: begin
        if (mcnt != 3'd4) begin
          pp <= (mcnt[0] ? {1'b0, amag[62:32]} : amag[31:0]) *
                (mcnt[1] ? {1'b0, bmag[62:32]} : bmag[31:0]);
          pp_sh <= 7'(({1'b0, mcnt[0]} + {1'b0, mcnt[1]}) * 32);
        end
        if (mcnt != 3'd0) prod <= prod + (128'(pp) << pp_sh);
        mcnt <= mcnt + 3'd1;
      end
      ST_FIN: begin
        if (sum > SAT62) acc <= SAT62;
        else if (sum < -SAT62) acc <= -SAT62;
        else acc <= sum;
        hstep <= hstep + 2'd1;
      end
      ST_RES: begin
        if (half > 64'sd2147483647) res_data <= 32'h7FFF_FFFF;
        else if (half < -64'sd2147483648) res_data <= 32'h8000_0000;
        else res_data <= half[31:0];
      end
      default: ;
    endcase
  end

  // a query holds off the input until its result has moved to the output register
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == FUNC_QUERY |=> !s_tready)
    else $error("input taken while a query is in progress");

  // a refused query always reports zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("out of range result is not zero");

  // clamped left knot leaves room for its right neighbor
  assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> 32'(k) + 32'd2 <= 32'(n))
    else $error("left knot beyond clamp");

  // the table is written only between items
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_IDLE && s_tuser == FUNC_LOAD)
    else $error("table write outside a load");

endmodule
`default_nettype wire
